// ===== rtl/core/kwt_pkg.sv =====
package kwt_pkg;

   typedef logic signed [63:0]  s64_type;
   typedef logic signed [127:0] s128_type;

   localparam int TsWidth   = 48;
   localparam int CsrIdxW   = 2;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_INITIAL_ESTIMATE  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_PROCESS_NOISE     = 2'd2;

   localparam logic [47:0] RNOISE_RESET = 48'd2814749767107;
   localparam logic [47:0] QNOISE_RESET = 48'd2814749767;
   localparam s64_type     ONE_Q48      = 64'sh0001_0000_0000_0000;
   localparam s64_type     S64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam s64_type     S64_MIN      = 64'sh8000_0000_0000_0000;

   localparam logic CMD_UPDATE   = 1'b0;
   localparam logic CMD_ESTIMATE = 1'b1;

   // Saturate a 128-bit signed value to the signed 64-bit range.
   function automatic s64_type sat64(input s128_type v);
      s64_type r;
      if (v[127:63] == {65{1'b0}} || v[127:63] == {65{1'b1}}) begin
         r = v[63:0];
      end else if (v[127]) begin
         r = S64_MIN;
      end else begin
         r = S64_MAX;
      end
      return r;
   endfunction

   function automatic s128_type sext128(input s64_type v);
      return {{64{v[63]}}, v};
   endfunction

endpackage

// ===== rtl/core/kwt_mul.sv =====
module kwt_mul (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kwt_pkg::s64_type a,
   input  kwt_pkg::s64_type b,
   output logic             done,
   output kwt_pkg::s128_type product
);

   logic [63:0]  xm_ff, ym_ff;
   logic         neg_ff;
   logic [127:0] acc_ff;
   logic [1:0]   cnt_ff;
   logic         busy_ff, fin_ff, done_ff;
   kwt_pkg::s128_type prod_ff;

   logic [31:0]  xh_in, yh_in;
   logic [63:0]  pp_in;
   logic [127:0] sh_in;

   // One 32x32 partial product per cycle; the half selects come from the count.
   always_comb begin
      xh_in = cnt_ff[0] ? xm_ff[63:32] : xm_ff[31:0];
      yh_in = cnt_ff[1] ? ym_ff[63:32] : ym_ff[31:0];
      pp_in = xh_in * yh_in;
      unique case ({1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]})
         2'd0:    sh_in = {64'd0, pp_in};
         2'd1:    sh_in = {32'd0, pp_in, 32'd0};
         default: sh_in = {pp_in, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            xm_ff   <= a[63] ? 64'(-a) : 64'(a);
            ym_ff   <= b[63] ? 64'(-b) : 64'(b);
            neg_ff  <= a[63] ^ b[63];
            acc_ff  <= '0;
            cnt_ff  <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + sh_in;
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            prod_ff <= neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff && !fin_ff)
      else $error("multiplier done while still working");
   assert property (@(posedge clock) disable iff (reset) fin_ff |=> done_ff)
      else $error("multiplier finish did not raise done");
   assert property (@(posedge clock) disable iff (reset) !(busy_ff && fin_ff))
      else $error("multiplier busy and finishing together");

endmodule

// ===== rtl/core/kwt_div.sv =====
module kwt_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kwt_pkg::s64_type num,
   input  kwt_pkg::s64_type den,
   output logic             done,
   output kwt_pkg::s64_type quotient
);

   logic [127:0] nq_ff;
   logic [63:0]  rem_ff, den_ff;
   logic         neg_ff, busy_ff, fin_ff, done_ff;
   logic [6:0]   cnt_ff;
   kwt_pkg::s64_type quo_ff;

   logic [63:0]  rtry_in;
   logic         ge_in;
   logic [63:0]  mag_in;

   // The remainder stays below the divisor, which is below 2^63, so 64 bits hold it.
   always_comb begin
      rtry_in = {rem_ff[62:0], nq_ff[127]};
      ge_in   = rtry_in >= den_ff;
      mag_in  = num[63] ? 64'(-num) : 64'(num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            nq_ff   <= {16'd0, mag_in, 48'd0};
            rem_ff  <= '0;
            den_ff  <= den;
            neg_ff  <= num[63];
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge_in ? rtry_in - den_ff : rtry_in;
            nq_ff  <= {nq_ff[126:0], ge_in};
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            if (nq_ff[127:63] != '0) begin
               quo_ff <= neg_ff ? -kwt_pkg::S64_MAX : kwt_pkg::S64_MAX;
            end else begin
               quo_ff <= neg_ff ? -$signed(nq_ff[63:0]) : $signed(nq_ff[63:0]);
            end
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset) fin_ff |=> done_ff)
      else $error("divider finish did not raise done");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");

endmodule

// ===== rtl/core/kalman_watermark_tracker_top.sv =====
// Channel   Direction  Signals                                   Meaning
// req       in         req_valid/ready, cmd, timestamp, watermark  update or estimate
// rsp       out        rsp_valid/ready, estimated_watermark        one per estimate
// csr       in         csr_valid/ready, csr_index, csr_data        register write
//
// An estimate needs one 64x64 product, formed as 4 partial products on the shared 32x32
// multiplier; before the first update it returns the initial estimate register instead.
// An update needs nine products on the multiplier and two 128-step divisions by S on the
// shared bit-serial divider; with S not positive only the four prediction products run.
// Reset is synchronous and restores the filter state and registers.
// A request is taken while a result waits in the output register; the block then
// holds the next result until the waiting one is taken.
module kalman_watermark_tracker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [47:0] req_timestamp,
   input  logic [47:0] req_watermark,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_estimated_watermark,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_GO   = 3'd1;
   localparam logic [2:0] S_MUL_WAIT = 3'd2;
   localparam logic [2:0] S_DIV_GO   = 3'd3;
   localparam logic [2:0] S_DIV_WAIT = 3'd4;
   localparam logic [2:0] S_CORR     = 3'd5;
   localparam logic [2:0] S_OUT      = 3'd6;

   localparam logic [3:0] OP_EST  = 4'd0;
   localparam logic [3:0] OP_PPOS = 4'd1;
   localparam logic [3:0] OP_P01  = 4'd2;
   localparam logic [3:0] OP_P00A = 4'd3;
   localparam logic [3:0] OP_P00B = 4'd4;
   localparam logic [3:0] OP_DIV0 = 4'd5;
   localparam logic [3:0] OP_DIV1 = 4'd6;
   localparam logic [3:0] OP_KPOS = 4'd7;
   localparam logic [3:0] OP_KVEL = 4'd8;
   localparam logic [3:0] OP_KP00 = 4'd9;
   localparam logic [3:0] OP_KP11 = 4'd10;
   localparam logic [3:0] OP_KP01 = 4'd11;

   logic [2:0]  state_ff;
   logic [3:0]  op_ff;
   logic [47:0] ts_ff, wm_ff;
   logic [47:0] init_ff, rnoise_ff, qnoise_ff;
   logic [47:0] last_time_ff;
   logic        seeded_ff;
   kwt_pkg::s64_type pos_ff, vel_ff, p00_ff, p01_ff, p11_ff;
   kwt_pkg::s64_type p01n_ff, y_ff, s_ff, k0_ff, k1_ff;
   kwt_pkg::s128_type t_ff;
   logic [47:0] res_ff;
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   logic [47:0]       d48_in;
   kwt_pkg::s64_type  dx_in, mul_a_in, mul_b_in, div_num_in, s_in;
   kwt_pkg::s128_type mp, e_in;
   kwt_pkg::s64_type  dq;
   logic              mul_done, div_done;

   always_comb begin
      d48_in = ts_ff - last_time_ff;
      dx_in  = {{16{d48_in[47]}}, d48_in};
      unique case (op_ff)
         OP_EST, OP_PPOS: begin mul_a_in = dx_in; mul_b_in = vel_ff;  end
         OP_P01:          begin mul_a_in = dx_in; mul_b_in = p11_ff;  end
         OP_P00A:         begin mul_a_in = dx_in; mul_b_in = p01_ff;  end
         OP_P00B:         begin mul_a_in = dx_in; mul_b_in = p01n_ff; end
         OP_KPOS:         begin mul_a_in = k0_ff; mul_b_in = y_ff;    end
         OP_KVEL:         begin mul_a_in = k1_ff; mul_b_in = y_ff;    end
         OP_KP00:         begin mul_a_in = k0_ff; mul_b_in = p00_ff;  end
         OP_KP11:         begin mul_a_in = k1_ff; mul_b_in = p01_ff;  end
         default:         begin mul_a_in = k0_ff; mul_b_in = p01_ff;  end
      endcase
      div_num_in = (op_ff == OP_DIV0) ? p00_ff : p01_ff;
      s_in = kwt_pkg::sat64(kwt_pkg::sext128(p00_ff) + {80'd0, rnoise_ff});
      e_in = (kwt_pkg::sext128(pos_ff) + (mp >>> 32)) >>> 16;
   end

   kwt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_MUL_GO),
      .a       (mul_a_in),
      .b       (mul_b_in),
      .done    (mul_done),
      .product (mp)
   );

   kwt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .num      (div_num_in),
      .den      (s_ff),
      .done     (div_done),
      .quotient (dq)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_estimated_watermark = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_EST;
         init_ff      <= '0;
         rnoise_ff    <= kwt_pkg::RNOISE_RESET;
         qnoise_ff    <= kwt_pkg::QNOISE_RESET;
         last_time_ff <= '0;
         seeded_ff    <= 1'b0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         p00_ff       <= kwt_pkg::ONE_Q48;
         p01_ff       <= '0;
         p11_ff       <= kwt_pkg::ONE_Q48;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               kwt_pkg::CSR_INITIAL_ESTIMATE:  init_ff   <= csr_data;
               kwt_pkg::CSR_MEASUREMENT_NOISE: rnoise_ff <= csr_data;
               kwt_pkg::CSR_PROCESS_NOISE:     qnoise_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ts_ff  <= req_timestamp;
                  wm_ff  <= req_watermark;
                  if (req_cmd == kwt_pkg::CMD_UPDATE) begin
                     op_ff    <= OP_PPOS;
                     state_ff <= S_MUL_GO;
                  end else if (seeded_ff) begin
                     op_ff    <= OP_EST;
                     state_ff <= S_MUL_GO;
                  end else begin
                     res_ff   <= init_ff;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_MUL_GO: state_ff <= S_MUL_WAIT;
            S_MUL_WAIT: begin
               if (mul_done) begin
                  op_ff <= op_ff + 4'd1;
                  unique case (op_ff)
                     OP_EST: begin
                        if (e_in[127]) begin
                           res_ff <= '0;
                        end else if (e_in[127:48] != '0) begin
                           res_ff <= '1;
                        end else begin
                           res_ff <= e_in[47:0];
                        end
                        state_ff <= S_OUT;
                     end
                     OP_PPOS: begin
                        pos_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(pos_ff) + (mp >>> 32));
                        state_ff <= S_MUL_GO;
                     end
                     OP_P01: begin
                        p01n_ff  <= kwt_pkg::sat64(kwt_pkg::sext128(p01_ff) + mp);
                        state_ff <= S_MUL_GO;
                     end
                     OP_P00A: begin
                        t_ff     <= kwt_pkg::sext128(p00_ff) + mp;
                        state_ff <= S_MUL_GO;
                     end
                     OP_P00B: begin
                        p00_ff   <= kwt_pkg::sat64(t_ff + mp + {80'd0, qnoise_ff});
                        p01_ff   <= p01n_ff;
                        p11_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(p11_ff)
                                                   + {80'd0, qnoise_ff});
                        state_ff <= S_CORR;
                     end
                     OP_KPOS: begin
                        pos_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(pos_ff) + (mp >>> 48));
                        state_ff <= S_MUL_GO;
                     end
                     OP_KVEL: begin
                        vel_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(vel_ff) + (mp >>> 16));
                        state_ff <= S_MUL_GO;
                     end
                     OP_KP00: begin
                        p00_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(p00_ff) - (mp >>> 48));
                        state_ff <= S_MUL_GO;
                     end
                     OP_KP11: begin
                        p11_ff   <= kwt_pkg::sat64(kwt_pkg::sext128(p11_ff) - (mp >>> 48));
                        state_ff <= S_MUL_GO;
                     end
                     default: begin
                        // Last correction term: the update is complete.
                        p01_ff       <= kwt_pkg::sat64(kwt_pkg::sext128(p01_ff) - (mp >>> 48));
                        last_time_ff <= ts_ff;
                        seeded_ff    <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CORR: begin
               y_ff <= kwt_pkg::sat64({64'd0, wm_ff, 16'd0} - kwt_pkg::sext128(pos_ff));
               s_ff <= s_in;
               if (s_in <= 0) begin
                  // No usable innovation variance: keep only the prediction.
                  last_time_ff <= ts_ff;
                  seeded_ff    <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  op_ff    <= OP_DIV0;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  op_ff <= op_ff + 4'd1;
                  if (op_ff == OP_DIV0) begin
                     k0_ff    <= dq;
                     state_ff <= S_DIV_GO;
                  end else begin
                     k1_ff    <= dq;
                     state_ff <= S_MUL_GO;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) mul_done |-> state_ff == S_MUL_WAIT)
      else $error("multiplier result outside its wait state");
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider result outside its wait state");
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output state");
   assert property (@(posedge clock) disable iff (reset) !$fell(seeded_ff))
      else $error("seeded flag dropped without reset");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_DIV_GO) |-> s_ff > 0)
      else $error("division started with non-positive S");

endmodule

// ===== bench/kalman_watermark_tracker_top_tb.sv =====
`timescale 1ns / 100ps

module kalman_watermark_tracker_top_tb;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam int SETTLE_CYCLES = 400;
   localparam int PHASE_ITEMS = 300;

   typedef logic signed [63:0] fx64_type;
   typedef logic signed [127:0] fx128_type;

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic        cmd;
      logic [47:0] ts;
      logic [47:0] wm;
      bit          typed;
      logic [47:0] want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [47:0] req_timestamp = '0;
   logic [47:0] req_watermark = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_estimated_watermark;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_data = '0;
   logic        csr_ready;

   kalman_watermark_tracker_top dut (.*);

   always #5 clock = ~clock;

   // Tracker copy of the block.
   logic [47:0] init_est, meas_noise, proc_noise, prev_time;
   fx64_type    pos, vel, p00, p01, p11;
   bit          seeded;

   logic [47:0] estimate_queue[$];
   int          mismatches = 0;
   int          estimates_seen = 0;
   int          updates_sent = 0;

   function automatic fx64_type clamp64(fx128_type v);
      if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
      return v[127] ? kwt_pkg::S64_MIN : kwt_pkg::S64_MAX;
   endfunction

   function automatic fx64_type delta_time(logic [47:0] ts);
      logic [47:0] d;
      d = ts - prev_time;
      return {{16{d[47]}}, d};
   endfunction

   function automatic fx64_type gain_q48(fx64_type num, fx64_type den);
      fx128_type m, dw, q;
      dw = den;
      m = (num < 0) ? -fx128_type'(num) : fx128_type'(num);
      q = fx128_type'($unsigned(m << 48) / $unsigned(dw));
      if ($unsigned(q) > $unsigned(fx128_type'(kwt_pkg::S64_MAX)))
         return (num < 0) ? -kwt_pkg::S64_MAX : kwt_pkg::S64_MAX;
      return (num < 0) ? -q[63:0] : q[63:0];
   endfunction

   function automatic logic [47:0] predict_watermark(logic [47:0] ts);
      fx128_type xd, xv, xp, e;
      if (!seeded) return init_est;
      xd = delta_time(ts);
      xv = vel;
      xp = pos;
      e = (xp + ((xd * xv) >>> 32)) >>> 16;
      if (e < 0) return '0;
      if (e > fx128_type'({80'd0, MAX48})) return MAX48;
      return e[47:0];
   endfunction

   task automatic absorb_measurement(logic [47:0] ts, logic [47:0] wm);
      fx128_type xd, xq, xr, t, xy, k0w, k1w;
      fx64_type  p01n, y, s, k0, k1, a00, a01, a11;
      xd = delta_time(ts);
      xq = fx128_type'({80'd0, proc_noise});
      xr = fx128_type'({80'd0, meas_noise});
      pos = clamp64(fx128_type'(pos) + ((xd * fx128_type'(vel)) >>> 32));
      p01n = clamp64(fx128_type'(p01) + xd * fx128_type'(p11));
      t = fx128_type'(p00) + xd * fx128_type'(p01) + xd * fx128_type'(p01n) + xq;
      p01 = p01n;
      p00 = clamp64(t);
      p11 = clamp64(fx128_type'(p11) + xq);
      y = clamp64(fx128_type'({64'd0, wm, 16'd0}) - fx128_type'(pos));
      s = clamp64(fx128_type'(p00) + xr);
      // A non-positive innovation variance leaves only the prediction.
      if (s > 0) begin
         a00 = p00;
         a01 = p01;
         a11 = p11;
         k0 = gain_q48(a00, s);
         k1 = gain_q48(a01, s);
         k0w = k0;
         k1w = k1;
         xy = y;
         pos = clamp64(fx128_type'(pos) + ((k0w * xy) >>> 48));
         vel = clamp64(fx128_type'(vel) + ((k1w * xy) >>> 16));
         p00 = clamp64(fx128_type'(a00) - ((k0w * fx128_type'(a00)) >>> 48));
         p01 = clamp64(fx128_type'(a01) - ((k0w * fx128_type'(a01)) >>> 48));
         p11 = clamp64(fx128_type'(a11) - ((k1w * fx128_type'(a01)) >>> 48));
      end
      prev_time = ts;
      seeded = 1'b1;
   endtask

   // Drives one request; called at a clock edge, returns at the accepting edge.
   task automatic send_request(logic cmd, logic [47:0] ts, logic [47:0] wm,
                               bit typed, logic [47:0] want);
      int gap;
      logic [47:0] e;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_timestamp <= ts;
      req_watermark <= wm;
      do @(posedge clock); while (!req_ready);
      if (cmd == kwt_pkg::CMD_ESTIMATE) begin
         e = predict_watermark(ts);
         estimate_queue.push_back(typed ? want : e);
      end else begin
         absorb_measurement(ts, wm);
         updates_sent++;
      end
   endtask

   task automatic write_register(logic [1:0] idx, logic [47:0] value);
      req_valid <= 1'b0;
      while (estimate_queue.size() != 0) @(posedge clock);
      // Updates produce no response, so give the last one time to finish.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         kwt_pkg::CSR_INITIAL_ESTIMATE:  init_est = value;
         kwt_pkg::CSR_MEASUREMENT_NOISE: meas_noise = value;
         kwt_pkg::CSR_PROCESS_NOISE:     proc_noise = value;
         default: ;
      endcase
   endtask

   function automatic logic [47:0] pick_noise();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MAX48;
         2: return kwt_pkg::RNOISE_RESET;
         3: return kwt_pkg::QNOISE_RESET;
         4: return 48'({$urandom, $urandom});
         default: return 48'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 16);
      endcase
   endfunction

   // Response side: random backpressure, with calm stretches.
   int  stall_left = 0;
   bit  calm = 1'b0;
   always @(posedge clock) begin
      logic [47:0] want;
      logic next_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         estimates_seen++;
         if (estimate_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response estimated_watermark=%h", rsp_estimated_watermark);
         end else begin
            want = estimate_queue.pop_front();
            if (rsp_estimated_watermark !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("estimated_watermark mismatch: expected %h actual %h",
                           want, rsp_estimated_watermark);
            end
         end
         if ($urandom_range(0, 40) == 0) calm = !calm;
         stall_left = calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_ready <= next_ready;
   end

   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      logic [47:0]  ts_cursor, wm_base, slope, ts, wm;
      int           phase, n;
      bit           est;

      init_est = '0;
      meas_noise = kwt_pkg::RNOISE_RESET;
      proc_noise = kwt_pkg::QNOISE_RESET;
      prev_time = '0;
      pos = '0;
      vel = '0;
      p00 = kwt_pkg::ONE_Q48;
      p01 = '0;
      p11 = kwt_pkg::ONE_Q48;
      seeded = 1'b0;

      rows = '{
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'd77, 48'd0, 1, 48'd0},
         '{1, kwt_pkg::CSR_INITIAL_ESTIMATE, 0, 0, MAX48, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, MAX48, MAX48, 1, MAX48},
         '{1, kwt_pkg::CSR_INITIAL_ESTIMATE, 0, 0, 48'd12345, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'd0, 48'd0, 1, 48'd12345},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'd100, 48'd1000, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'd100, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'd200, 48'd2000, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, MAX48, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'd0, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, MAX48, MAX48, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'd0, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'h8000_0000_0000, 48'd0, 0, 0},
         '{1, kwt_pkg::CSR_MEASUREMENT_NOISE, 0, 0, 48'd0, 0, 0},
         '{1, kwt_pkg::CSR_PROCESS_NOISE, 0, 0, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'd10, 48'd10, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'd20, 48'd0, 0, 0},
         '{1, kwt_pkg::CSR_PROCESS_NOISE, 0, 0, MAX48, 0, 0},
         '{1, kwt_pkg::CSR_MEASUREMENT_NOISE, 0, 0, MAX48, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFF, MAX48, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, 48'h7FFF_FFFF_FFFF, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFE, 48'd0, 0, 0},
         '{0, 0, kwt_pkg::CMD_ESTIMATE, MAX48, 48'd0, 0, 0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_register(rows[i].idx, rows[i].wm);
         else send_request(rows[i].cmd, rows[i].ts, rows[i].wm, rows[i].typed, rows[i].want);
      end

      for (phase = 0; phase < 5; phase++) begin
         write_register(kwt_pkg::CSR_MEASUREMENT_NOISE,
                        phase == 0 ? kwt_pkg::RNOISE_RESET : pick_noise());
         write_register(kwt_pkg::CSR_PROCESS_NOISE,
                        phase == 0 ? kwt_pkg::QNOISE_RESET : pick_noise());
         write_register(kwt_pkg::CSR_INITIAL_ESTIMATE, 48'({$urandom, $urandom}));
         ts_cursor = 48'({$urandom, $urandom});
         wm_base = 48'({$urandom, $urandom});
         slope = $urandom_range(0, 50);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            est = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) begin
               // Noise: every field fully random.
               ts = 48'({$urandom, $urandom});
               wm = 48'({$urandom, $urandom});
            end else begin
               ts_cursor = ts_cursor + $urandom_range(0, 2000);
               wm_base = wm_base + slope * $urandom_range(0, 2000);
               ts = est ? ts_cursor + $urandom_range(0, 500) : ts_cursor;
               wm = wm_base + $urandom_range(0, 64) - 32;
            end
            send_request(est ? kwt_pkg::CMD_ESTIMATE : kwt_pkg::CMD_UPDATE, ts, wm, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (estimate_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d updates and checked %0d estimates over several noise settings.",
               updates_sent, estimates_seen);
      $display("Mismatches: %0d, pending estimates: %0d.", mismatches, estimate_queue.size());
      if (mismatches == 0 && estimate_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/kwt_pkg.sv
rtl/core/kwt_mul.sv
rtl/core/kwt_div.sv
rtl/core/kalman_watermark_tracker_top.sv
bench/kalman_watermark_tracker_top_tb.sv
